// ===== src/summed_area_table_macros.svh =====
// assertion macros shared by the summed-area table rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef SUMMED_AREA_TABLE_MACROS_SVH
`define SUMMED_AREA_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sat_pkg.sv =====
// shared types and constants of the summed-area table
// no dependencies; imported by every module of the block but sat_ram
package sat_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    // configuration register fields
    localparam int CFG_W       = 13;
    localparam int H_MAX       = 4096;
    localparam int ROW_W       = $clog2(H_MAX);
    localparam int HCNT_W      = ROW_W + 1;
    localparam int WCNT_W      = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int FW_RESET    = 640;
    localparam int FH_RESET    = 480;
    localparam int CFG_IDX_W   = 1;

    // channel arithmetic
    localparam int NUM_CH = 4;
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 32;

    // queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_alpha;
        logic             frame_end;
    } t_result;

    // lane 3 is red, lane 0 is alpha
    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_px_lanes;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sums;

    // classified pixel handed from front to back
    typedef struct packed {
        t_pixel           pixel;
        logic [COL_W-1:0] col;
        logic             forced;
        logic             frame_end;
    } t_work;

endpackage

// ===== src/sat_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sat_front.sv =====
// front end: geometry registers, row/column tracking and pixel classification
// depends on sat_pkg and summed_area_table_macros.svh
`include "summed_area_table_macros.svh"

module sat_front import sat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  t_pixel           i_pixel,
    output t_work            o_work
);

    logic [CFG_W-1:0]  r_fw;
    logic [CFG_W-1:0]  r_fh;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic [WCNT_W-1:0] w;
    logic [HCNT_W-1:0] h;
    logic [WCNT_W-1:0] fw_ext;
    logic [HCNT_W-1:0] fh_ext;
    logic [WCNT_W-1:0] col_ext;
    logic [HCNT_W-1:0] row_ext;
    logic [HCNT_W-1:0] row_inc;
    logic              col_wrap;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;

    assign o_cfg_ready = 1'b1;

    // saturate geometry to the supported range
    always_comb begin
        fw_ext = WCNT_W'(r_fw);
        fh_ext = HCNT_W'(r_fh);
        if (fw_ext < WCNT_W'(2)) begin
            w = WCNT_W'(2);
        end else if (fw_ext > WCNT_W'(MAX_WIDTH)) begin
            w = WCNT_W'(MAX_WIDTH);
        end else begin
            w = fw_ext;
        end
        if (fh_ext < HCNT_W'(2)) begin
            h = HCNT_W'(2);
        end else if (fh_ext > HCNT_W'(H_MAX)) begin
            h = HCNT_W'(H_MAX);
        end else begin
            h = fh_ext;
        end
    end

    // position of this pixel, with wrap for a shrunk geometry
    always_comb begin
        col_wrap = WCNT_W'(r_col) >= w;
        col      = col_wrap ? '0 : r_col;
        row_inc  = col_wrap ? HCNT_W'(r_row) + HCNT_W'(1) : HCNT_W'(r_row);
        row      = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
        col_ext  = WCNT_W'(col);
        row_ext  = HCNT_W'(row);
    end

    // position of the following pixel
    always_comb begin
        if (col_ext + WCNT_W'(1) >= w) begin
            n_col = '0;
            n_row = (row_ext + HCNT_W'(1) >= h) ? '0 : ROW_W'(row_ext + HCNT_W'(1));
        end else begin
            n_col = COL_W'(col_ext + WCNT_W'(1));
            n_row = row;
        end
    end

    // classified transaction for the back end
    always_comb begin
        o_work.pixel     = i_pixel;
        o_work.col       = col;
        o_work.forced    = (row == '0) || (col == '0);
        o_work.frame_end = (row_ext == h - HCNT_W'(1)) && (col_ext == w - WCNT_W'(1));
    end

    // geometry registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= CFG_W'(FW_RESET);
            r_fh  <= CFG_W'(FH_RESET);
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                endcase
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // assertions
    `SAT_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_accept && o_work.frame_end, r_col == '0 && r_row == '0, "frame end not followed by frame start")
    `SAT_ASSERT_SAME(a_col_in_range, i_clk, i_rst_n, i_accept, col_ext < w, "classified column outside row")

endmodule

// ===== src/sat_queue.sv =====
// short queue of classified pixels between front and back
// depends on sat_pkg
module sat_queue import sat_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_work i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_work o_rdata,
    output logic  o_empty
);

    localparam int QA_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wp;
    logic [QA_W-1:0]   r_rp;
    logic [QC_W-1:0]   r_cnt;

    assign o_full  = r_cnt == QC_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (i_rd) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

endmodule

// ===== src/sat_back.sv =====
// back end: line store access, summed-area arithmetic and result queue
// depends on sat_pkg, sat_ram and summed_area_table_macros.svh
`include "summed_area_table_macros.svh"

module sat_back import sat_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_work   i_work,
    input  logic    i_work_empty,
    output logic    o_work_pop,
    output t_result o_result,
    output logic    o_empty,
    input  logic    i_pop
);

    localparam int OA_W = (OUT_DEPTH > 2) ? $clog2(OUT_DEPTH) : 1;
    localparam int OC_W = $clog2(OUT_DEPTH + 1) + 1;

    typedef struct packed {
        t_sums            diff;
        logic [COL_W-1:0] col;
        logic             forced;
        logic             frame_end;
    } t_stage2;

    // read stage
    logic             r_b1v;
    t_work            r_b1;
    t_sums            ram_rdata;
    t_sums            above;
    t_sums            n_diff;
    t_px_lanes        px;
    logic             fwd_hit;
    t_sums            r_ul;

    // sum stage
    logic             r_b2v;
    t_stage2          r_b2;
    t_sums            s;
    t_sums            r_left;

    // last line store write, for the read-during-write case
    logic             r_wv;
    logic [COL_W-1:0] r_wcol;
    t_sums            r_wdata;

    // result queue
    t_result          r_out [OUT_DEPTH];
    logic [OA_W-1:0]  r_out_wp;
    logic [OA_W-1:0]  r_out_rp;
    logic [OC_W-1:0]  r_out_cnt;
    logic [OC_W-1:0]  occ;
    logic             out_pop;
    t_result          n_res;

    // take a transaction only with room for everything in flight
    always_comb begin
        occ        = r_out_cnt + OC_W'(r_b1v) + OC_W'(r_b2v);
        o_work_pop = !i_work_empty && (occ < OC_W'(OUT_DEPTH));
    end

    sat_ram #(
        .WIDTH ($bits(t_sums)),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_b2v),
        .i_waddr (r_b2.col),
        .i_wdata (s),
        .i_raddr (i_work.col),
        .o_rdata (ram_rdata)
    );

    // above value with bypass, then pixel + above - upper-left
    always_comb begin
        px      = t_px_lanes'(r_b1.pixel);
        fwd_hit = r_wv && (r_wcol == r_b1.col);
        above   = fwd_hit ? r_wdata : ram_rdata;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_diff[ch] = SUM_W'(px[ch]) + above[ch] - r_ul[ch];
        end
    end

    // add the left neighbor; border pixels are zero
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            s[ch] = r_b2.forced ? '0 : r_b2.diff[ch] + r_left[ch];
        end
        n_res.sum_red   = s[3];
        n_res.sum_green = s[2];
        n_res.sum_blue  = s[1];
        n_res.sum_alpha = s[0];
        n_res.frame_end = r_b2.frame_end;
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_b1 <= i_work;
        end
        if (r_b1v) begin
            r_b2.diff      <= n_diff;
            r_b2.col       <= r_b1.col;
            r_b2.forced    <= r_b1.forced;
            r_b2.frame_end <= r_b1.frame_end;
        end
        if (r_b2v) begin
            r_wcol               <= r_b2.col;
            r_wdata              <= s;
            r_out[r_out_wp]      <= n_res;
        end
    end

    // pipeline control and running neighbor sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1v  <= 1'b0;
            r_b2v  <= 1'b0;
            r_wv   <= 1'b0;
            r_ul   <= '0;
            r_left <= '0;
        end else begin
            r_b1v <= o_work_pop;
            r_b2v <= r_b1v;
            r_wv  <= r_b2v;
            if (r_b1v) begin
                r_ul <= r_b1.forced ? '0 : above;
            end
            if (r_b2v) begin
                r_left <= s;
            end
        end
    end

    // result queue pointers
    assign out_pop  = i_pop && !o_empty;
    assign o_empty  = r_out_cnt == '0;
    assign o_result = r_out[r_out_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wp  <= '0;
            r_out_rp  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (r_b2v) begin
                r_out_wp <= (r_out_wp == OA_W'(OUT_DEPTH - 1)) ? '0 : r_out_wp + OA_W'(1);
            end
            if (out_pop) begin
                r_out_rp <= (r_out_rp == OA_W'(OUT_DEPTH - 1)) ? '0 : r_out_rp + OA_W'(1);
            end
            if (r_b2v && !out_pop) begin
                r_out_cnt <= r_out_cnt + OC_W'(1);
            end else if (out_pop && !r_b2v) begin
                r_out_cnt <= r_out_cnt - OC_W'(1);
            end
        end
    end

    // assertions
    `SAT_ASSERT_SAME(a_adjacent_cols, i_clk, i_rst_n, r_b1v && r_b2v, r_b1.col != r_b2.col, "adjacent transactions share a line store column")
    `SAT_ASSERT_SAME(a_out_room, i_clk, i_rst_n, r_b2v, r_out_cnt < OC_W'(OUT_DEPTH), "result queue written while full")
    `SAT_ASSERT_NEXT(a_left_cleared, i_clk, i_rst_n, r_b2v && r_b2.forced, r_left == '0, "left sum not cleared on border pixel")

endmodule

// ===== src/summed_area_table.sv =====
// top level of the summed-area table
// depends on sat_pkg, sat_front, sat_queue and sat_back
//
// Streams an RGBA frame in row-major order and returns one four-channel
// summed-area value per pixel, each channel 32 bits wrapping modulo 2^32;
// row 0 and column 0 read as zero. One pixel is taken per clock while full
// is low, passing the input queue, the line store's registered read and the
// left-neighbor add. The previous row lives in a MAX_WIDTH x 128-bit line
// store with one write and one read per cycle; it needs no clearing after
// reset, since row 0 fills it before any read is used. The user writes width
// and height through the configuration port (index 0 width, index 1 height)
// only while no transaction is in flight, which the block does not enforce;
// values are saturated to 2..MAX_WIDTH and 2..4096. Results wait in a
// four-entry queue behind a four-entry input queue, so up to eight
// transactions are taken while the consumer holds off pop before full rises.
module summed_area_table import sat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  t_pixel           i_pixel,
    output logic             empty,
    input  logic             pop,
    output t_result          o_result
);

    logic  accept;
    t_work work_in;
    t_work work_head;
    logic  work_empty;
    logic  work_pop;

    assign accept = push && !full;

    // classify incoming pixels
    sat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_work      (work_in)
    );

    // decoupling queue
    sat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (work_in),
        .o_full  (full),
        .i_rd    (work_pop),
        .o_rdata (work_head),
        .o_empty (work_empty)
    );

    // arithmetic and result queue
    sat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (work_head),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule
